### rtl/tdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg: shared types and constants of the timer deadline queue
// Item kinds, field widths and the saturation limit of the status delay.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_W         = 64;
    localparam int ID_W           = 4;
    localparam int DELAY_OUT_W    = 31;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_REPEAT  = 2'd1;
    localparam logic [1:0] KIND_STOP    = 2'd2;
    localparam logic [1:0] KIND_ADVANCE = 2'd3;

    localparam logic [TIME_W-1:0] SAT_LIMIT = 64'd2147483647;

    // command broadcast from the controller to every timer cell
    typedef struct packed {
        logic              cmd_valid;   // apply start/repeat/stop to sel cell
        logic [1:0]        kind;
        logic [5:0]        sel;         // addressed timer
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now_time;
        logic              fire_valid;  // disarm/rearm sel cell on expiry
    } tdq_cmd_t;

    // minimum candidate carried along the cell chain
    typedef struct packed {
        logic              found;
        logic [5:0]        idx;
        logic [TIME_W-1:0] deadline;
    } tdq_min_t;

endpackage

### rtl/tdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_cell: one timer slot
// Holds deadline, period and armed flag; registers the running minimum of the
// chain so the earliest deadline ripples one cell per cycle.
// ----------------------------------------------------------------------------
module tdq_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tdq_pkg::tdq_cmd_t cmd,
    input  tdq_pkg::tdq_min_t min_in,
    output tdq_pkg::tdq_min_t min_out
);

    logic [tdq_pkg::TIME_W-1:0] deadline_reg;
    logic [tdq_pkg::TIME_W-1:0] period_reg;
    logic                       armed_reg;
    tdq_pkg::tdq_min_t          min_reg;
    tdq_pkg::tdq_min_t          min_next;
    logic                       hit;

    assign hit = (cmd.sel == 6'(IDX));

    always_comb
    begin
        min_next = min_in;
        // strict less keeps the lower index on ties (chain runs from index 0)
        if (armed_reg && (!min_in.found || deadline_reg < min_in.deadline))
        begin
            min_next.found    = 1'b1;
            min_next.idx      = 6'(IDX);
            min_next.deadline = deadline_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg <= '0;
            period_reg   <= '0;
            armed_reg    <= 1'b0;
            min_reg      <= '0;
        end
        else
        begin
            min_reg <= min_next;
            if (cmd.cmd_valid && hit)
            begin
                case (cmd.kind)
                    tdq_pkg::KIND_START:
                    begin
                        if (!armed_reg)
                        begin
                            armed_reg    <= 1'b1;
                            deadline_reg <= cmd.now_time + cmd.delay;
                        end
                    end
                    tdq_pkg::KIND_REPEAT:
                    begin
                        period_reg <= cmd.delay;
                        if (!armed_reg)
                        begin
                            armed_reg    <= 1'b1;
                            deadline_reg <= cmd.now_time + cmd.delay;
                        end
                    end
                    tdq_pkg::KIND_STOP:
                    begin
                        armed_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.fire_valid && hit)
            begin
                if (period_reg != '0)
                    deadline_reg <= cmd.now_time + period_reg;
                else
                    armed_reg <= 1'b0;
            end
        end
    end

    assign min_out = min_reg;

endmodule

### rtl/timer_deadline_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue: bank of one-shot / periodic timers
// Items enter on s_axis with the kind on tuser (start, repeat, stop, advance).
// Each item produces zero or more expiry transfers on m_axis (tuser=1), then
// one status transfer (tlast=1) with the delay to the earliest armed deadline
// or the none-pending flag.
// The timers sit in a chain of NUM_TIMERS cells; the running minimum moves one
// cell per cycle, and each search waits in ST_SCAN for it to settle.
// The status transfer of a start, repeat or stop is made after ST_CMD, ST_SCAN
// and ST_OUT; an advance adds ST_FIRE, ST_CMD and ST_SCAN per fired
// timer. One item is in work at a time; s_axis_tready is high only while the
// block is idle, so a new item is taken only after the last one is done.
// Results leave through an output register; when m_axis_tready is low the
// block holds the result and waits, losing nothing, and each cycle of stall
// adds to the item time.
// Reset clears all timers to disarmed, deadlines, periods and time to zero.
// ----------------------------------------------------------------------------
module timer_deadline_queue #(
    parameter int NUM_TIMERS = tdq_pkg::NUM_TIMERS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // timer_id[3:0], delay[67:4],
                                        // now_value[131:68], zero pad
    input  logic [1:0]   s_axis_tuser,  // kind[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,  // fired_timer[3:0], next_delay[34:4],
                                        // none_pending[35], zero pad
    output logic         m_axis_tuser,  // expired[0]
    output logic         m_axis_tlast
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_FIRE,
        ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           fires_reg;
    logic [1:0]                 kind_reg;
    logic [tdq_pkg::ID_W-1:0]   id_reg;
    logic [tdq_pkg::TIME_W-1:0] delay_reg;
    logic [tdq_pkg::TIME_W-1:0] now_reg;
    logic                       out_valid_reg;
    logic [39:0]                out_data_reg;
    logic                       out_user_reg;
    logic                       out_last_reg;
    logic                       fire_reg;
    logic [5:0]                 fire_idx_reg;

    tdq_pkg::tdq_cmd_t          cmd;
    tdq_pkg::tdq_min_t          chain [NUM_TIMERS+1];
    tdq_pkg::tdq_min_t          best;
    logic [tdq_pkg::TIME_W-1:0] diff;
    logic [30:0]                sat_delay;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_TIMERS; g++)
        begin : g_cell
            tdq_cell #(
                .IDX (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .min_in  (chain[g]),
                .min_out (chain[g+1])
            );
        end
    endgenerate

    assign best = chain[NUM_TIMERS];

    always_comb
    begin
        cmd            = '0;
        cmd.kind       = kind_reg;
        cmd.sel        = fire_reg ? fire_idx_reg : 6'(id_reg);
        cmd.delay      = delay_reg;
        cmd.now_time   = now_reg;
        cmd.cmd_valid  = (state_reg == ST_CMD) && (kind_reg != tdq_pkg::KIND_ADVANCE)
                         && ({2'b0, id_reg} < 6'(NUM_TIMERS));
        cmd.fire_valid = fire_reg;
    end

    assign diff      = best.deadline - now_reg;
    assign sat_delay = (diff >= tdq_pkg::SAT_LIMIT) ? 31'h7FFFFFFF : diff[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            fires_reg     <= '0;
            kind_reg      <= '0;
            id_reg        <= '0;
            delay_reg     <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            fire_reg      <= 1'b0;
            fire_idx_reg  <= '0;
        end
        else
        begin
            // disarm/rearm strobe for the cell just reported
            fire_reg <= (state_reg == ST_FIRE) && !out_valid_reg;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        kind_reg  <= s_axis_tuser;
                        id_reg    <= s_axis_tdata[3:0];
                        delay_reg <= s_axis_tdata[67:4];
                        if (s_axis_tuser == tdq_pkg::KIND_ADVANCE)
                            now_reg <= s_axis_tdata[131:68];
                        fires_reg <= '0;
                        state_reg <= ST_CMD;
                    end
                end
                ST_CMD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // wait for the minimum to ripple through every cell
                    if (cnt_reg == CNT_W'(NUM_TIMERS + 1))
                    begin
                        if (kind_reg == tdq_pkg::KIND_ADVANCE && best.found
                            && best.deadline <= now_reg
                            && fires_reg != CNT_W'(NUM_TIMERS))
                            state_reg <= ST_FIRE;
                        else
                            state_reg <= ST_OUT;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_FIRE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {36'd0, best.idx[3:0]};
                        out_user_reg  <= 1'b1;
                        out_last_reg  <= 1'b0;
                        fire_idx_reg  <= best.idx;
                        fires_reg     <= fires_reg + 1'b1;
                        state_reg     <= ST_CMD;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_user_reg  <= 1'b0;
                        out_last_reg  <= 1'b1;
                        if (best.found)
                            out_data_reg <= {4'd0, 1'b0, sat_delay, 4'd0};
                        else
                            out_data_reg <= {4'd0, 1'b1, 31'd0, 4'd0};
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
